// ===== hdl/lsbr_pkg.sv =====
// shared types, constants and helpers for the lcd shadow buffer refresh unit
// no dependencies; compiled first
package lsbr_pkg;

    // display geometry
    localparam int ROWS          = 2;
    localparam int STORE_COLS    = 16;
    localparam int COL_W         = 4;
    localparam int STORE_DEPTH   = ROWS * STORE_COLS;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int ROW_CHARS_DEF = 16;

    // byte codes
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CMD_SET_ADDR = 8'h80;
    localparam logic [7:0] ROW1_OFFSET  = 8'h40;

    // operation codes of an input word
    typedef enum logic [2:0] {
        OP_CHAR     = 3'd0,
        OP_HEX_BYTE = 3'd1,
        OP_HEX_WORD = 3'd2,
        OP_CLEAR    = 3'd3,
        OP_TICK     = 3'd4
    } t_op;

    // datapath action of one microcode step
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_WCHAR,
        ACT_WHEX,
        ACT_CLEAR,
        ACT_READ,
        ACT_ADDR,
        ACT_DATA
    } t_act;

    // sequencer control to datapath
    typedef struct packed {
        t_act       act;
        logic [1:0] nib;
        logic [1:0] coff;
        logic       srow;
        logic       mark;
        logic       load;
    } t_ctrl;

    // datapath status to sequencer
    typedef struct packed {
        logic row_clean;
        logic stall;
    } t_stat;

    // lowercase ascii hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] d);
        logic [7:0] base;
        base = (d < 4'd10) ? 8'h30 : 8'h57;
        return base + {4'h0, d};
    endfunction

endpackage

// ===== hdl/lsbr_in_if.sv =====
// input channel of the lcd shadow buffer refresh unit: one command word
// no dependencies
interface lsbr_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  operation;
    logic        row;
    logic [3:0]  col;
    logic [15:0] value;

    modport source (output valid, operation, row, col, value, input ready);
    modport sink   (input valid, operation, row, col, value, output ready);
endinterface

// ===== hdl/lsbr_out_if.sv =====
// output channel of the lcd shadow buffer refresh unit: one display byte
// no dependencies
interface lsbr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;

    modport source (output valid, lcd_byte, is_data, last, input ready);
    modport sink   (input valid, lcd_byte, is_data, last, output ready);
endinterface

// ===== hdl/lcd_shadow_buffer_refresh_unit.sv =====
// top level of the lcd shadow buffer refresh unit
// depends on lsbr_pkg, lsbr_in_if, lsbr_out_if, lsbr_sequencer, lsbr_datapath
//
//   channel | dir | carries
//   i_in    | in  | operation, row, col, value (one command word)
//   o_out   | out | lcd_byte, is_data, last (one display word)
//
// one microcode step per cycle while the output is free, plus the idle
// step that takes the word; char, hex byte and hex word writes put one
// character a step through one store write port, and a refresh tick
// sends one character of each dirty row. reset is synchronous; the store
// reads as spaces through per-entry written flags, so no clearing pass
// follows reset. a full output register holds the address or data step.
module lcd_shadow_buffer_refresh_unit #(
    parameter int ROW_CHARS = lsbr_pkg::ROW_CHARS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lsbr_in_if.sink    i_in,
    lsbr_out_if.source o_out
);
    import lsbr_pkg::*;

    t_ctrl w_ctrl;
    t_stat w_stat;
    logic  w_in_ready;

    assign i_in.ready = w_in_ready;

    // step sequencer
    lsbr_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_op       (i_in.operation),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_ctrl     (w_ctrl)
    );

    // store and refresh datapath
    lsbr_datapath #(
        .ROW_CHARS (ROW_CHARS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .i_row       (i_in.row),
        .i_col       (i_in.col),
        .i_value     (i_in.value),
        .i_out_ready (o_out.ready),
        .o_stat      (w_stat),
        .o_out_valid (o_out.valid),
        .o_lcd_byte  (o_out.lcd_byte),
        .o_is_data   (o_out.is_data),
        .o_last      (o_out.last)
    );

`ifndef SYNTHESIS
    // a word with a used operation code starts a program
    a_dispatch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && w_in_ready
         && (i_in.operation == OP_CHAR || i_in.operation == OP_HEX_BYTE
             || i_in.operation == OP_HEX_WORD || i_in.operation == OP_CLEAR
             || i_in.operation == OP_TICK))
        |=> !w_in_ready)
        else $error("used operation did not leave idle");

    // a set-address command is always followed by data, so never last
    a_cmd_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.is_data) |-> !o_out.last)
        else $error("set-address command marked last");

    // no command word is taken while display words are being produced
    a_busy_serve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctrl.act == ACT_ADDR || w_ctrl.act == ACT_DATA) |-> !w_in_ready)
        else $error("input ready during refresh");
`endif

endmodule

// ===== hdl/lsbr_sequencer.sv =====
// microcode rom, step counter and jump logic of the refresh unit
// depends on lsbr_pkg
module lsbr_sequencer (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [2:0]      i_op,
    input  lsbr_pkg::t_stat i_stat,
    output logic            o_in_ready,
    output lsbr_pkg::t_ctrl o_ctrl
);
    import lsbr_pkg::*;

    typedef logic [3:0] t_step;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_IDLE,
        JMP_DISPATCH,
        JMP_IF_CLEAN
    } t_jmp;

    typedef struct packed {
        t_act       act;
        logic [1:0] nib;
        logic [1:0] coff;
        logic       srow;
        logic       mark;
        t_jmp       jmp;
        t_step      target;
    } t_uword;

    // program entry points
    localparam t_step ST_IDLE  = 4'd0;
    localparam t_step ST_CHAR  = 4'd1;
    localparam t_step ST_BHI   = 4'd2;
    localparam t_step ST_BLO   = 4'd3;
    localparam t_step ST_W3    = 4'd4;
    localparam t_step ST_W2    = 4'd5;
    localparam t_step ST_W1    = 4'd6;
    localparam t_step ST_W0    = 4'd7;
    localparam t_step ST_CLR   = 4'd8;
    localparam t_step ST_RD0   = 4'd9;
    localparam t_step ST_AD0   = 4'd10;
    localparam t_step ST_DT0   = 4'd11;
    localparam t_step ST_RD1   = 4'd12;
    localparam t_step ST_AD1   = 4'd13;
    localparam t_step ST_DT1   = 4'd14;

    // control store
    function automatic t_uword rom(input t_step s);
        t_uword w;
        w = '{act: ACT_NONE, nib: 2'd0, coff: 2'd0, srow: 1'b0, mark: 1'b0,
              jmp: JMP_IDLE, target: ST_IDLE};
        case (s)
            ST_IDLE: w.jmp = JMP_DISPATCH;
            ST_CHAR: begin
                w.act = ACT_WCHAR; w.mark = 1'b1;
            end
            ST_BHI: begin
                w.act = ACT_WHEX; w.nib = 2'd1; w.coff = 2'd0; w.jmp = JMP_NEXT;
            end
            ST_BLO: begin
                w.act = ACT_WHEX; w.nib = 2'd0; w.coff = 2'd1; w.mark = 1'b1;
            end
            ST_W3: begin
                w.act = ACT_WHEX; w.nib = 2'd3; w.coff = 2'd0; w.jmp = JMP_NEXT;
            end
            ST_W2: begin
                w.act = ACT_WHEX; w.nib = 2'd2; w.coff = 2'd1; w.jmp = JMP_NEXT;
            end
            ST_W1: begin
                w.act = ACT_WHEX; w.nib = 2'd1; w.coff = 2'd2; w.jmp = JMP_NEXT;
            end
            ST_W0: begin
                w.act = ACT_WHEX; w.nib = 2'd0; w.coff = 2'd3; w.mark = 1'b1;
            end
            ST_CLR: begin
                w.act = ACT_CLEAR; w.mark = 1'b1;
            end
            ST_RD0: begin
                w.act = ACT_READ; w.srow = 1'b0; w.jmp = JMP_IF_CLEAN; w.target = ST_RD1;
            end
            ST_AD0: begin
                w.act = ACT_ADDR; w.srow = 1'b0; w.jmp = JMP_NEXT;
            end
            ST_DT0: begin
                w.act = ACT_DATA; w.srow = 1'b0; w.jmp = JMP_NEXT;
            end
            ST_RD1: begin
                w.act = ACT_READ; w.srow = 1'b1; w.jmp = JMP_IF_CLEAN; w.target = ST_IDLE;
            end
            ST_AD1: begin
                w.act = ACT_ADDR; w.srow = 1'b1; w.jmp = JMP_NEXT;
            end
            ST_DT1: begin
                w.act = ACT_DATA; w.srow = 1'b1;
            end
            default: w.jmp = JMP_IDLE;
        endcase
        return w;
    endfunction

    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;
    t_step  w_entry;

    assign w_uw       = rom(r_step);
    assign o_in_ready = (r_step == ST_IDLE);

    // control word to datapath
    assign o_ctrl = '{act: w_uw.act, nib: w_uw.nib, coff: w_uw.coff, srow: w_uw.srow,
                      mark: w_uw.mark, load: o_in_ready && i_in_valid};

    // dispatch on the operation code; unused codes stay idle
    always_comb begin
        case (i_op)
            OP_CHAR:     w_entry = ST_CHAR;
            OP_HEX_BYTE: w_entry = ST_BHI;
            OP_HEX_WORD: w_entry = ST_W3;
            OP_CLEAR:    w_entry = ST_CLR;
            OP_TICK:     w_entry = ST_RD0;
            default:     w_entry = ST_IDLE;
        endcase
    end

    // next step
    always_comb begin
        n_step = r_step;
        if (!i_stat.stall) begin
            case (w_uw.jmp)
                JMP_NEXT:     n_step = r_step + 4'd1;
                JMP_IDLE:     n_step = ST_IDLE;
                JMP_DISPATCH: n_step = i_in_valid ? w_entry : ST_IDLE;
                JMP_IF_CLEAN: n_step = i_stat.row_clean ? w_uw.target : r_step + 4'd1;
                default:      n_step = ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= ST_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

// ===== hdl/lsbr_datapath.sv =====
// text store, per-row refresh state and output register of the refresh unit
// depends on lsbr_pkg
module lsbr_datapath #(
    parameter int ROW_CHARS = lsbr_pkg::ROW_CHARS_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lsbr_pkg::t_ctrl i_ctrl,
    input  logic            i_row,
    input  logic [3:0]      i_col,
    input  logic [15:0]     i_value,
    input  logic            i_out_ready,
    output lsbr_pkg::t_stat o_stat,
    output logic            o_out_valid,
    output logic [7:0]      o_lcd_byte,
    output logic            o_is_data,
    output logic            o_last
);
    import lsbr_pkg::*;

    localparam int CNT_W = $clog2(ROW_CHARS + 1);

    // text store and its written flags (unwritten entries read as space)
    logic [7:0]             r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;

    // latched command word
    logic              r_row;
    logic [COL_W-1:0]  r_col;
    logic [15:0]       r_value;

    // per-row refresh state
    logic [1:0]        r_dirty;
    logic [COL_W-1:0]  r_cursor [ROWS];
    logic [CNT_W-1:0]  r_sent [ROWS];
    logic              r_last_row;

    // registered store read
    logic [7:0]        r_rd_data;
    logic              r_rd_vld;

    // output register
    logic              r_out_valid;
    logic [7:0]        r_out_byte;
    logic              r_out_data;
    logic              r_out_last;

    logic [COL_W:0]    w_csum;
    logic              w_wen;
    logic [ADDR_W-1:0] w_waddr;
    logic [7:0]        w_wdata;
    logic [COL_W-1:0]  w_cur;
    logic [ADDR_W-1:0] w_raddr;
    logic              w_need_addr;
    logic              w_free;
    logic              w_emit_addr;
    logic              w_emit_data;
    logic [CNT_W-1:0]  w_sent_inc;
    logic              w_row_done;
    logic [7:0]        w_addr_byte;

    // write address and character; columns past the row end are dropped
    assign w_csum  = {1'b0, r_col} + {{(COL_W-1){1'b0}}, i_ctrl.coff};
    assign w_wen   = ((i_ctrl.act == ACT_WCHAR) || (i_ctrl.act == ACT_WHEX)) && !w_csum[COL_W];
    assign w_waddr = {r_row, w_csum[COL_W-1:0]};
    assign w_wdata = (i_ctrl.act == ACT_WCHAR) ? r_value[7:0]
                                                : hex_char(r_value[{i_ctrl.nib, 2'b00} +: 4]);

    // refresh of the selected row
    assign w_cur       = r_cursor[i_ctrl.srow];
    assign w_raddr     = {i_ctrl.srow, w_cur};
    assign w_need_addr = (i_ctrl.srow != r_last_row) || (w_cur == '0);
    assign w_free      = !r_out_valid || i_out_ready;
    assign w_emit_addr = (i_ctrl.act == ACT_ADDR) && w_need_addr && w_free;
    assign w_emit_data = (i_ctrl.act == ACT_DATA) && w_free;
    assign w_sent_inc  = r_sent[i_ctrl.srow] + 1'b1;
    assign w_row_done  = (w_sent_inc >= CNT_W'(ROW_CHARS));
    assign w_addr_byte = CMD_SET_ADDR | {4'h0, w_cur} | (i_ctrl.srow ? ROW1_OFFSET : 8'h00);

    // status back to the sequencer
    assign o_stat.row_clean = !r_dirty[i_ctrl.srow];
    assign o_stat.stall     = (((i_ctrl.act == ACT_ADDR) && w_need_addr)
                               || (i_ctrl.act == ACT_DATA)) && !w_free;

    assign o_out_valid = r_out_valid;
    assign o_lcd_byte  = r_out_byte;
    assign o_is_data   = r_out_data;
    assign o_last      = r_out_last;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_dirty     <= '0;
            r_cursor    <= '{default: '0};
            r_sent      <= '{default: '0};
            r_last_row  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_wen) begin
                r_vld[w_waddr] <= 1'b1;
            end
            if (i_ctrl.act == ACT_CLEAR) begin
                for (int c = 0; c < STORE_COLS; c++) begin
                    if (c < ROW_CHARS) begin
                        r_vld[{r_row, COL_W'(c)}] <= 1'b0;
                    end
                end
            end
            if (i_ctrl.mark) begin
                r_dirty[r_row] <= 1'b1;
                r_sent[r_row]  <= '0;
            end
            if (w_emit_addr) begin
                r_last_row <= i_ctrl.srow;
            end
            if (w_emit_data) begin
                r_cursor[i_ctrl.srow] <= w_cur + 1'b1;
                if (w_row_done) begin
                    r_dirty[i_ctrl.srow] <= 1'b0;
                    r_sent[i_ctrl.srow]  <= '0;
                end else begin
                    r_sent[i_ctrl.srow] <= w_sent_inc;
                end
            end
            if (w_emit_addr || w_emit_data) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // store, command latch and output payload
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_row   <= i_row;
            r_col   <= i_col;
            r_value <= i_value;
        end
        if (w_wen) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_ctrl.act == ACT_READ) begin
            r_rd_data <= r_mem[w_raddr];
            r_rd_vld  <= r_vld[w_raddr];
        end
        if (w_emit_addr) begin
            r_out_byte <= w_addr_byte;
            r_out_data <= 1'b0;
            r_out_last <= 1'b0;
        end else if (w_emit_data) begin
            r_out_byte <= r_rd_vld ? r_rd_data : CHAR_SPACE;
            r_out_data <= 1'b1;
            // upper row is last only when the lower row has nothing to send
            r_out_last <= i_ctrl.srow ? 1'b1 : !r_dirty[1];
        end
    end

endmodule
